/* rtl/core/peak_mask_spectrum_gain_defines.svh */
// Assertion macros for the checker file of this block.
`ifndef PEAK_MASK_SPECTRUM_GAIN_DEFINES_SVH
`define PEAK_MASK_SPECTRUM_GAIN_DEFINES_SVH

// Checked only while reset is released.
`define PMSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define PMSG_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/pmsg_pkg.sv */
`timescale 1ns / 1ps

package pmsg_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int BIN_W       = 12;
	localparam int FS_W        = 13;
	localparam int Q_W         = 16;
	localparam int IDX_W       = 4;
	localparam int POS_W       = BIN_W + Q_W;
	localparam int PROD_W      = Q_W + FS_W;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [FS_W-1:0] FS_RESET = 13'd1024;
	localparam logic [Q_W-1:0]  ONE_Q15  = 16'h8000;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_BIN  = 1'b1;

	localparam logic REG_FRAME_SIZE = 1'b0;
	localparam logic REG_STEREO     = 1'b1;

	typedef struct packed {
		logic                          mode;
		logic [IDX_W-1:0]              peak_index;
		logic                          peak_valid;
		logic [Q_W-1:0]                band_low;
		logic [Q_W-1:0]                band_high;
		logic [Q_W-1:0]                volume;
		logic signed [Q_W-1:0]         pan;
		logic [BIN_W-1:0]              bin_index;
		logic signed [SAMPLE_BITS-1:0] bin_value;
	} cmd_t;

	typedef struct packed {
		logic [BIN_W-1:0]              out_bin;
		logic signed [SAMPLE_BITS-1:0] out_first;
		logic signed [SAMPLE_BITS-1:0] out_second;
		logic                          matched;
	} res_t;

	// What walks down the cell chain for one bin.
	typedef struct packed {
		logic [BIN_W-1:0]      bin;
		logic                  hit;
		logic [Q_W-1:0]        vol;
		logic signed [Q_W-1:0] pan;
	} token_t;

	typedef struct packed {
		logic                  we;
		logic [IDX_W-1:0]      index;
		logic                  in_use;
		logic [Q_W-1:0]        low;
		logic [Q_W-1:0]        high;
		logic [Q_W-1:0]        vol;
		logic signed [Q_W-1:0] pan;
	} peak_load_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} gain_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GAIN,
		ST_MUL,
		ST_HOLD
	} state_t;

endpackage

/* rtl/core/pmsg_cell.sv */
`timescale 1ns / 1ps

module pmsg_cell #(
	parameter int IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmsg_pkg::peak_load_t         load,
	input  logic [pmsg_pkg::FS_W-1:0]    frame_size,
	input  pmsg_pkg::token_t             tok_in,
	output pmsg_pkg::token_t             tok_out
);

	logic                                in_use_q;
	logic [pmsg_pkg::Q_W-1:0]            low_q;
	logic [pmsg_pkg::Q_W-1:0]            high_q;
	logic [pmsg_pkg::Q_W-1:0]            vol_q;
	logic signed [pmsg_pkg::Q_W-1:0]     pan_q;
	logic [pmsg_pkg::PROD_W-1:0]         lo_prod_q;
	logic [pmsg_pkg::PROD_W-1:0]         hi_prod_q;
	pmsg_pkg::token_t                    tok_q;
	logic                                we;
	logic [pmsg_pkg::PROD_W-1:0]         pos;
	logic                                take;

	assign we = load.we && (int'(load.index) == IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
		end else if (we) begin
			in_use_q <= load.in_use;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			low_q  <= load.low;
			high_q <= load.high;
			vol_q  <= load.vol;
			pan_q  <= load.pan;
		end
	end

	// Edges, bin units << 16; user must change frame size only while idle, unchecked.
	always_ff @(posedge clk) begin
		lo_prod_q <= pmsg_pkg::PROD_W'(low_q) * pmsg_pkg::PROD_W'(frame_size);
		hi_prod_q <= pmsg_pkg::PROD_W'(high_q) * pmsg_pkg::PROD_W'(frame_size);
	end

	assign pos  = pmsg_pkg::PROD_W'({tok_in.bin, {pmsg_pkg::Q_W{1'b0}}});
	assign take = !tok_in.hit && in_use_q && (pos >= lo_prod_q) && (pos < hi_prod_q);

	// The first cell that covers the bin claims it; later cells pass it on.
	always_ff @(posedge clk) begin
		if (take) begin
			tok_q.bin <= tok_in.bin;
			tok_q.hit <= 1'b1;
			tok_q.vol <= vol_q;
			tok_q.pan <= pan_q;
		end else begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;

endmodule

/* rtl/core/pmsg_gain.sv */
`timescale 1ns / 1ps

module pmsg_gain (
	input  logic                                   clk,
	input  pmsg_pkg::gain_ctl_t                    ctl,
	input  pmsg_pkg::token_t                       tok,
	input  logic                                   pass,
	input  logic                                   stereo,
	input  logic signed [pmsg_pkg::SAMPLE_BITS-1:0] value,
	output logic signed [pmsg_pkg::SAMPLE_BITS-1:0] first,
	output logic signed [pmsg_pkg::SAMPLE_BITS-1:0] second
);

	localparam int SB  = pmsg_pkg::SAMPLE_BITS;
	localparam int QW  = pmsg_pkg::Q_W;
	localparam int PW  = SB + QW + 1;
	localparam int WW  = QW + 1;
	localparam int GPW = 2 * QW + 1;
	localparam logic signed [PW-1:0] S_MAX = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
	localparam logic signed [PW-1:0] S_MIN = {{(PW-SB+1){1'b1}}, {(SB-1){1'b0}}};

	logic [WW-1:0]           wt_l;
	logic [WW-1:0]           wt_r;
	logic [GPW-1:0]          gp_l;
	logic [GPW-1:0]          gp_r;
	logic [QW-1:0]           gain_l;
	logic [QW-1:0]           gain_r;
	logic [QW-1:0]           gain_l_s1;
	logic [QW-1:0]           gain_r_s1;
	logic signed [SB-1:0]    value_s1;
	logic signed [PW-1:0]    prod_l_s2;
	logic signed [PW-1:0]    prod_r_s2;
	logic signed [PW-1:0]    sh_l;
	logic signed [PW-1:0]    sh_r;

	function automatic logic signed [SB-1:0] saturate(input logic signed [PW-1:0] v);
		logic signed [SB-1:0] r;
		if (v > S_MAX) begin
			r = S_MAX[SB-1:0];
		end else if (v < S_MIN) begin
			r = S_MIN[SB-1:0];
		end else begin
			r = v[SB-1:0];
		end
		return r;
	endfunction

	// 1 - pan and 1 + pan in Q2.15, taken modulo 2^17; both stay within 0 to 65536.
	assign wt_l = 17'h08000 - {tok.pan[QW-1], tok.pan};
	assign wt_r = 17'h08000 + {tok.pan[QW-1], tok.pan};
	assign gp_l = GPW'(tok.vol) * GPW'(wt_l);
	assign gp_r = GPW'(tok.vol) * GPW'(wt_r);

	always_comb begin
		if (pass) begin
			gain_l = pmsg_pkg::ONE_Q15;
			gain_r = stereo ? pmsg_pkg::ONE_Q15 : '0;
		end else if (!tok.hit) begin
			gain_l = '0;
			gain_r = '0;
		end else if (!stereo) begin
			gain_l = tok.vol;
			gain_r = '0;
		end else begin
			gain_l = gp_l[2*QW-1:QW];
			gain_r = gp_r[2*QW-1:QW];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			gain_l_s1 <= gain_l;
			gain_r_s1 <= gain_r;
			value_s1  <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			prod_l_s2 <= PW'($signed({1'b0, gain_l_s1})) * PW'(value_s1);
			prod_r_s2 <= PW'($signed({1'b0, gain_r_s1})) * PW'(value_s1);
		end
	end

	// Arithmetic shift gives the floor of the Q1.15 product.
	assign sh_l   = prod_l_s2 >>> (QW - 1);
	assign sh_r   = prod_r_s2 >>> (QW - 1);
	assign first  = saturate(sh_l);
	assign second = saturate(sh_r);

endmodule

/* rtl/core/peak_mask_spectrum_gain.sv */
`timescale 1ns / 1ps
// Load item: taken without leaving idle; the next item may follow in the next cycle.
// Lower-half bin: the bin walks down the chain of MAX_PEAKS peak cells, one cell per cycle, in the scan
// state, then goes through the gain, multiply and hold states. Upper-half bin: the scan is skipped.
// No new item is taken while a bin is in flight; the block takes the next item once back in idle.
// Reset clears the sequencer, the in-use marks, the output valid and the registers to defaults;
// the band, volume and pan fields of an entry hold nothing useful until loaded.

module peak_mask_spectrum_gain #(
	parameter int MAX_PEAKS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_ready,
	input  pmsg_pkg::cmd_t                   cmd,
	output logic                             res_valid,
	input  logic                             res_ready,
	output pmsg_pkg::res_t                   res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pmsg_pkg::PADDR_W-1:0]     paddr,
	input  logic [pmsg_pkg::PDATA_W-1:0]     pwdata,
	output logic [pmsg_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	localparam int CNT_W = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;

	pmsg_pkg::state_t                        state_q;
	pmsg_pkg::state_t                        state_d;
	logic [CNT_W-1:0]                        cnt_q;
	logic [pmsg_pkg::FS_W-1:0]               fs_q;
	logic                                    stereo_q;
	logic [pmsg_pkg::BIN_W-1:0]              bin_q;
	logic signed [pmsg_pkg::SAMPLE_BITS-1:0] value_q;
	logic                                    pass_q;
	logic                                    hit_q;
	logic                                    out_valid_q;
	pmsg_pkg::res_t                          res_q;
	logic                                    cfg_we;
	logic                                    accept;
	logic                                    accept_bin;
	logic                                    lower;
	logic                                    out_load;
	pmsg_pkg::peak_load_t                    load;
	pmsg_pkg::gain_ctl_t                     gctl;
	pmsg_pkg::token_t                        chain [MAX_PEAKS+1];
	logic signed [pmsg_pkg::SAMPLE_BITS-1:0] first;
	logic signed [pmsg_pkg::SAMPLE_BITS-1:0] second;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q     <= pmsg_pkg::FS_RESET;
			stereo_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[pmsg_pkg::PADDR_W-1])
				pmsg_pkg::REG_FRAME_SIZE: begin
					fs_q <= pwdata[pmsg_pkg::FS_W-1:0];
				end
				pmsg_pkg::REG_STEREO: begin
					stereo_q <= pwdata[0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[pmsg_pkg::PADDR_W-1])
			pmsg_pkg::REG_FRAME_SIZE: prdata = pmsg_pkg::PDATA_W'(fs_q);
			pmsg_pkg::REG_STEREO:     prdata = pmsg_pkg::PDATA_W'(stereo_q);
		endcase
	end

	// Item intake.
	assign cmd_ready  = (state_q == pmsg_pkg::ST_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign accept_bin = accept && (cmd.mode == pmsg_pkg::MODE_BIN);
	assign lower      = cmd.bin_index < fs_q[pmsg_pkg::FS_W-1:1];

	assign load.we     = accept && (cmd.mode == pmsg_pkg::MODE_LOAD);
	assign load.index  = cmd.peak_index;
	assign load.in_use = cmd.peak_valid;
	assign load.low    = cmd.band_low;
	assign load.high   = cmd.band_high;
	assign load.vol    = cmd.volume;
	assign load.pan    = cmd.pan;

	always_ff @(posedge clk) begin
		if (accept_bin) begin
			bin_q   <= cmd.bin_index;
			value_q <= cmd.bin_value;
			pass_q  <= !lower;
		end
	end

	// The bin sits at the head of the chain for the whole scan.
	assign chain[0].bin = bin_q;
	assign chain[0].hit = 1'b0;
	assign chain[0].vol = '0;
	assign chain[0].pan = '0;

	for (genvar j = 0; j < MAX_PEAKS; j++) begin : g_cell
		pmsg_cell #(
			.IDX(j)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.load       (load),
			.frame_size (fs_q),
			.tok_in     (chain[j]),
			.tok_out    (chain[j+1])
		);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmsg_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pmsg_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	assign out_load = (state_q == pmsg_pkg::ST_HOLD) && (!out_valid_q || res_ready);

	always_comb begin
		state_d    = state_q;
		gctl.en_s1 = 1'b0;
		gctl.en_s2 = 1'b0;
		unique case (state_q)
			pmsg_pkg::ST_IDLE: begin
				if (accept_bin) begin
					state_d = lower ? pmsg_pkg::ST_SCAN : pmsg_pkg::ST_GAIN;
				end
			end
			pmsg_pkg::ST_SCAN: begin
				if (cnt_q == CNT_W'(MAX_PEAKS - 1)) begin
					state_d = pmsg_pkg::ST_GAIN;
				end
			end
			pmsg_pkg::ST_GAIN: begin
				gctl.en_s1 = 1'b1;
				state_d    = pmsg_pkg::ST_MUL;
			end
			pmsg_pkg::ST_MUL: begin
				gctl.en_s2 = 1'b1;
				state_d    = pmsg_pkg::ST_HOLD;
			end
			pmsg_pkg::ST_HOLD: begin
				if (out_load) begin
					state_d = pmsg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pmsg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (gctl.en_s1) begin
			hit_q <= chain[MAX_PEAKS].hit && !pass_q;
		end
	end

	pmsg_gain u_gain (
		.clk    (clk),
		.ctl    (gctl),
		.tok    (chain[MAX_PEAKS]),
		.pass   (pass_q),
		.stereo (stereo_q),
		.value  (value_q),
		.first  (first),
		.second (second)
	);

	// Output register; it frees the sequencer while the result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.out_bin    <= bin_q;
			res_q.out_first  <= first;
			res_q.out_second <= second;
			res_q.matched    <= hit_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

endmodule

/* rtl/core/pmsg_checker.sv */
`timescale 1ns / 1ps
`include "peak_mask_spectrum_gain_defines.svh"

module pmsg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input pmsg_pkg::cmd_t               cmd,
	input logic                         res_valid,
	input logic                         res_ready,
	input pmsg_pkg::res_t               res
);

	// A waiting result keeps its valid and its contents.
	`PMSG_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res), "result item changed while stalled")

	// A bin item occupies the block for at least the next cycle.
	`PMSG_ASSERT(a_bin_busy, cmd_valid && cmd_ready && cmd.mode == pmsg_pkg::MODE_BIN |=> !cmd_ready, "ready stayed high after a bin item")

	// A load item completes at once.
	`PMSG_ASSERT(a_load_quick, cmd_valid && cmd_ready && cmd.mode == pmsg_pkg::MODE_LOAD |=> cmd_ready, "ready dropped after a load item")

	// Reset leaves the block empty and ready.
	`PMSG_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !res_valid && cmd_ready, "block not empty after reset")

endmodule

bind peak_mask_spectrum_gain pmsg_checker u_pmsg_checker (.*);

/* tb/peak_mask_spectrum_gain_test.sv */
`timescale 1ns / 1ps

module peak_mask_spectrum_gain_test;

	localparam int MAX_PEAKS = 16;
	localparam int SETTLE = MAX_PEAKS + 8;
	localparam int LIMIT = 400000;
	localparam logic [pmsg_pkg::PADDR_W-1:0] FRAME_ADDR = {pmsg_pkg::REG_FRAME_SIZE, 2'b00};
	localparam logic [pmsg_pkg::PADDR_W-1:0] STEREO_ADDR = {pmsg_pkg::REG_STEREO, 2'b00};
	localparam longint SAMPLE_MAX = (64'sd1 <<< (pmsg_pkg::SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	logic clk;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	pmsg_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	pmsg_pkg::res_t res;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pmsg_pkg::PADDR_W-1:0] paddr = '0;
	logic [pmsg_pkg::PDATA_W-1:0] pwdata = '0;
	logic [pmsg_pkg::PDATA_W-1:0] prdata;
	logic pready;

	peak_mask_spectrum_gain #(.MAX_PEAKS(MAX_PEAKS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Local copy of the peak table and the registers.
	logic [pmsg_pkg::Q_W-1:0] band_lo_tab [MAX_PEAKS];
	logic [pmsg_pkg::Q_W-1:0] band_hi_tab [MAX_PEAKS];
	logic [pmsg_pkg::Q_W-1:0] vol_tab [MAX_PEAKS];
	logic signed [pmsg_pkg::Q_W-1:0] pan_tab [MAX_PEAKS];
	logic peak_live [MAX_PEAKS];
	logic [pmsg_pkg::FS_W-1:0] frame_len = pmsg_pkg::FS_RESET;
	logic stereo_on = 1'b0;

	pmsg_pkg::cmd_t cmd_queue [$];
	pmsg_pkg::res_t bins_due [$];

	int fails = 0;
	int bins_seen = 0;
	int bins_in_band = 0;
	int loads_taken = 0;
	int settings = 1;
	int cycles = 0;
	int send_hold = 0;
	int sink_hold = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	initial begin
		for (int i = 0; i < MAX_PEAKS; i++) begin
			band_lo_tab[i] = '0;
			band_hi_tab[i] = '0;
			vol_tab[i] = '0;
			pan_tab[i] = '0;
			peak_live[i] = 1'b0;
		end
	end

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic longint clip_sample(input longint v);
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		return v;
	endfunction

	function automatic void store_peak(input pmsg_pkg::cmd_t c);
		peak_live[c.peak_index] = c.peak_valid;
		band_lo_tab[c.peak_index] = c.band_low;
		band_hi_tab[c.peak_index] = c.band_high;
		vol_tab[c.peak_index] = c.volume;
		pan_tab[c.peak_index] = c.pan;
	endfunction

	function automatic pmsg_pkg::res_t scale_bin(input pmsg_pkg::cmd_t c);
		pmsg_pkg::res_t r;
		longint pos;
		longint val;
		longint vol;
		longint pn;
		longint gl;
		longint gr;
		longint fs;
		bit found;
		r = '0;
		r.out_bin = c.bin_index;
		val = longint'($signed(c.bin_value));
		fs = longint'(frame_len);
		pos = longint'(c.bin_index) <<< 16;
		found = 1'b0;
		if (longint'(c.bin_index) >= (fs >>> 1)) begin
			r.out_first = c.bin_value;
			r.out_second = stereo_on ? c.bin_value : '0;
			return r;
		end
		// Lowest matching entry wins.
		for (int j = 0; j < MAX_PEAKS; j++) begin
			if (!found && peak_live[j] && pos >= longint'(band_lo_tab[j]) * fs
					&& pos < longint'(band_hi_tab[j]) * fs) begin
				found = 1'b1;
				vol = longint'(vol_tab[j]);
				r.matched = 1'b1;
				if (stereo_on) begin
					pn = longint'(pan_tab[j]);
					gl = (vol * (32768 - pn)) >>> 16;
					gr = (vol * (32768 + pn)) >>> 16;
					r.out_first = pmsg_pkg::SAMPLE_BITS'(clip_sample((gl * val) >>> 15));
					r.out_second = pmsg_pkg::SAMPLE_BITS'(clip_sample((gr * val) >>> 15));
				end else begin
					r.out_first = pmsg_pkg::SAMPLE_BITS'(clip_sample((vol * val) >>> 15));
				end
			end
		end
		return r;
	endfunction

	function automatic pmsg_pkg::cmd_t peak_item(input int idx, input bit live, input int lo,
			input int hi, input int vol, input int pn);
		pmsg_pkg::cmd_t c;
		c = '0;
		c.mode = pmsg_pkg::MODE_LOAD;
		c.peak_index = pmsg_pkg::IDX_W'(idx);
		c.peak_valid = live;
		c.band_low = pmsg_pkg::Q_W'(lo);
		c.band_high = pmsg_pkg::Q_W'(hi);
		c.volume = pmsg_pkg::Q_W'(vol);
		c.pan = pmsg_pkg::Q_W'(pn);
		return c;
	endfunction

	function automatic pmsg_pkg::cmd_t bin_item(input int bin, input int val);
		pmsg_pkg::cmd_t c;
		c = '0;
		c.mode = pmsg_pkg::MODE_BIN;
		c.bin_index = pmsg_pkg::BIN_W'(bin);
		c.bin_value = pmsg_pkg::SAMPLE_BITS'(val);
		return c;
	endfunction

	function automatic pmsg_pkg::cmd_t random_item();
		pmsg_pkg::cmd_t c;
		int half;
		int top;
		int lo;
		int span;
		int pick;
		half = int'(frame_len) / 2;
		top = (int'(frame_len) - 1 > 4095) ? 4095 : int'(frame_len) - 1;
		c.mode = ($urandom_range(0, 3) == 0) ? pmsg_pkg::MODE_LOAD : pmsg_pkg::MODE_BIN;
		c.peak_index = pmsg_pkg::IDX_W'($urandom);
		c.peak_valid = ($urandom_range(0, 4) != 0);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			c.band_low = pmsg_pkg::Q_W'($urandom);
			c.band_high = pmsg_pkg::Q_W'($urandom);
		end else begin
			// Most bands sit over the lower half so that bins land in them.
			lo = (pick == 1) ? 0 : $urandom_range(0, 34000);
			span = $urandom_range(0, 24000);
			c.band_low = pmsg_pkg::Q_W'(lo);
			c.band_high = pmsg_pkg::Q_W'((lo + span > 65535) ? 65535 : lo + span);
		end
		pick = $urandom_range(0, 9);
		c.volume = (pick == 0) ? '0 : (pick == 1) ? pmsg_pkg::ONE_Q15 :
			pmsg_pkg::Q_W'($urandom_range(0, 32768));
		pick = $urandom_range(0, 9);
		c.pan = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7fff : pmsg_pkg::Q_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 7)
			c.bin_index = pmsg_pkg::BIN_W'($urandom_range(0, half - 1));
		else if (pick < 9)
			c.bin_index = pmsg_pkg::BIN_W'($urandom_range(half, top));
		else
			c.bin_index = pmsg_pkg::BIN_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			c.bin_value = 24'sh7fffff;
		else if (pick == 1)
			c.bin_value = 24'sh800000;
		else if (pick == 2)
			c.bin_value = pmsg_pkg::SAMPLE_BITS'($urandom_range(0, 511))
				- pmsg_pkg::SAMPLE_BITS'(256);
		else
			c.bin_value = pmsg_pkg::SAMPLE_BITS'($urandom);
		return c;
	endfunction

	task automatic apb_write(input logic [pmsg_pkg::PADDR_W-1:0] addr,
			input logic [pmsg_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Waits until every item is taken and every result is back, then lets a
	// trailing load finish inside the block.
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || cmd_valid || bins_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_phase(input int fs, input bit st, input int n, input bit idle);
		drain();
		apb_write(FRAME_ADDR, pmsg_pkg::PDATA_W'(fs));
		frame_len = pmsg_pkg::FS_W'(fs);
		apb_write(STEREO_ADDR, pmsg_pkg::PDATA_W'(st));
		stereo_on = st;
		settings++;
		@(negedge clk);
		src_idle_on = idle && ($urandom_range(0, 3) != 0);
		sink_idle_on = idle && ($urandom_range(0, 3) != 0);
		repeat (n) cmd_queue.push_back(random_item());
	endtask

	always @(posedge clk) begin : drive_cmd
		logic take;
		take = cmd_valid && cmd_ready;
		if (take) begin
			if (cmd.mode == pmsg_pkg::MODE_LOAD) begin
				store_peak(cmd);
				loads_taken++;
			end else begin
				bins_due.push_back(scale_bin(cmd));
			end
		end
		if (arst_n && (!cmd_valid || take)) begin
			if (send_hold != 0) begin
				send_hold <= send_hold - 1;
				cmd_valid <= 1'b0;
			end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
				send_hold <= $urandom_range(0, 12);
				cmd_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				cmd <= cmd_queue.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_res
		pmsg_pkg::res_t want;
		if (res_valid && res_ready) begin
			if (bins_due.size() == 0) begin
				$error("result for bin %0d with no item waiting", res.out_bin);
				fails++;
			end else begin
				want = bins_due.pop_front();
				bins_seen++;
				if (want.matched)
					bins_in_band++;
				if (res.out_bin !== want.out_bin) begin
					$error("out_bin: expected %0d, got %0d", want.out_bin, res.out_bin);
					fails++;
				end
				if (res.out_first !== want.out_first) begin
					$error("out_first: expected %0d, got %0d", want.out_first, res.out_first);
					fails++;
				end
				if (res.out_second !== want.out_second) begin
					$error("out_second: expected %0d, got %0d", want.out_second,
						res.out_second);
					fails++;
				end
				if (res.matched !== want.matched) begin
					$error("matched: expected %0d, got %0d", want.matched, res.matched);
					fails++;
				end
			end
		end
		if (arst_n) begin
			if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				res_ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
				sink_hold <= $urandom_range(0, 12);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("peak_mask_spectrum_gain: mismatch");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// Reset settings: 1024 observations, mono, so the lower half is bins 0 to 511.
		cmd_queue.push_back(peak_item(0, 1'b1, 0, 16384, 32768, 0));
		cmd_queue.push_back(peak_item(1, 1'b1, 0, 32768, 65535, -32768));
		cmd_queue.push_back(peak_item(15, 1'b1, 65535, 65535, 0, 32767));
		cmd_queue.push_back(peak_item(2, 1'b0, 0, 65535, 16384, 0));
		cmd_queue.push_back(bin_item(0, 8388607));
		cmd_queue.push_back(bin_item(255, -8388608));
		// Entries 0 and 1 both cover bin 255; past it only entry 1 does, and
		// its volume above 1.0 drives the result into saturation.
		cmd_queue.push_back(bin_item(256, 8388607));
		cmd_queue.push_back(bin_item(300, -8388608));
		cmd_queue.push_back(bin_item(511, 1));
		cmd_queue.push_back(bin_item(512, -1));
		cmd_queue.push_back(bin_item(1023, 8388607));
		cmd_queue.push_back(bin_item(4095, -8388608));
		cmd_queue.push_back(bin_item(100, 0));
		cmd_queue.push_back(peak_item(0, 1'b0, 0, 16384, 32768, 0));
		cmd_queue.push_back(bin_item(10, 4660));
		cmd_queue.push_back(peak_item(1, 1'b0, 0, 32768, 65535, -32768));
		cmd_queue.push_back(bin_item(10, 4660));
		// A band whose low edge falls exactly on bin 511.
		cmd_queue.push_back(peak_item(14, 1'b1, 32704, 32768, 12345, -1));
		cmd_queue.push_back(bin_item(511, -12345));
		cmd_queue.push_back(bin_item(510, 77777));
		cmd_queue.push_back(peak_item(3, 1'b1, 0, 65535, 49152, 12345));
		cmd_queue.push_back(bin_item(50, 8000000));
		repeat (250) cmd_queue.push_back(random_item());

		run_phase(4096, 1'b1, 300, 1'b1);
		run_phase(2, 1'b0, 150, 1'b1);
		run_phase(2, 1'b1, 150, 1'b1);
		run_phase(2 * $urandom_range(1, 2047) + 1, 1'b1, 300, 1'b1);
		run_phase(4096, 1'b0, 300, 1'b1);
		run_phase(1024, 1'b1, 300, 1'b0);
		drain();

		if (bins_due.size() != 0) begin
			$error("%0d expected results never arrived", bins_due.size());
			fails++;
		end
		$display("Checked %0d bin results (%0d inside a peak band) and %0d table loads",
			bins_seen, bins_in_band, loads_taken);
		$display("over %0d frame size and stereo settings, in mono and stereo.", settings);
		if (fails == 0)
			$display("peak_mask_spectrum_gain: match");
		else
			$display("peak_mask_spectrum_gain: mismatch");
		$finish;
	end

endmodule
